// ===== hw/rtl/ebalu_pkg.sv =====
package ebalu_pkg;

	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	localparam logic [2:0] OP_ALU  = 3'd0;
	localparam logic [2:0] OP_ACC  = 3'd1;
	localparam logic [2:0] OP_INC  = 3'd2;
	localparam logic [2:0] OP_DEC  = 3'd3;
	localparam logic [2:0] OP_PREF = 3'd4;

	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_ADC = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_SBC = 3'd3;
	localparam logic [2:0] ALU_AND = 3'd4;
	localparam logic [2:0] ALU_XOR = 3'd5;
	localparam logic [2:0] ALU_OR  = 3'd6;
	localparam logic [2:0] ALU_CP  = 3'd7;

	localparam logic [2:0] ACC_RLCA = 3'd0;
	localparam logic [2:0] ACC_RRCA = 3'd1;
	localparam logic [2:0] ACC_RLA  = 3'd2;
	localparam logic [2:0] ACC_RRA  = 3'd3;
	localparam logic [2:0] ACC_DAA  = 3'd4;
	localparam logic [2:0] ACC_CPL  = 3'd5;
	localparam logic [2:0] ACC_SCF  = 3'd6;
	localparam logic [2:0] ACC_CCF  = 3'd7;

	localparam logic [1:0] GRP_SHIFT = 2'd0;
	localparam logic [1:0] GRP_BIT   = 2'd1;
	localparam logic [1:0] GRP_RES   = 2'd2;
	localparam logic [1:0] GRP_SET   = 2'd3;

	localparam logic [2:0] SH_RLC  = 3'd0;
	localparam logic [2:0] SH_RRC  = 3'd1;
	localparam logic [2:0] SH_RL   = 3'd2;
	localparam logic [2:0] SH_RR   = 3'd3;
	localparam logic [2:0] SH_SLA  = 3'd4;
	localparam logic [2:0] SH_SRA  = 3'd5;
	localparam logic [2:0] SH_SWAP = 3'd6;
	localparam logic [2:0] SH_SRL  = 3'd7;

	localparam logic [7:0] DAA_LIMIT = 8'h99;
	localparam logic [3:0] DAA_NIB   = 4'h9;
	localparam logic [7:0] DAA_LO    = 8'h06;
	localparam logic [7:0] DAA_HI    = 8'h60;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] code;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [3:0] flags_in;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags_out;
		logic       write_result;
	} alu_rsp_t;

endpackage

// ===== hw/rtl/eight_bit_alu_with_bit_unit.sv =====
// From the accepting edge of start to the done strobe, an item passes
// through the input register, then the result register.
// Throughput: one item per cycle; busy is always low.
// Reset: arst_n clears the valid bits asynchronously; no result is strobed
// until a new item is accepted. The receiver cannot stall: done lasts one cycle.
module eight_bit_alu_with_bit_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ebalu_pkg::alu_req_t  request,
	output logic                 done,
	output ebalu_pkg::alu_rsp_t  response
);
	import ebalu_pkg::*;

	logic     valid_s1, valid_s2;
	alu_req_t req_s1;
	alu_rsp_t rsp_comb, rsp_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// payload registers: hold only when no item is moving in
	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= request;
		end
		if (valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	ebalu_exec u_exec (
		.req (req_s1),
		.rsp (rsp_comb)
	);

	assign done     = valid_s2;
	assign response = rsp_s2;

endmodule

// ===== hw/rtl/ebalu_exec.sv =====
module ebalu_exec (
	input  ebalu_pkg::alu_req_t req,
	output ebalu_pkg::alu_rsp_t rsp
);
	import ebalu_pkg::*;

	logic [7:0] a, b;
	logic [3:0] f;
	logic [2:0] sel;
	logic [1:0] grp;
	logic [7:0] mask;
	logic       cia, cis;
	logic [8:0] add9, sub9;
	logic [4:0] addh, subh;
	logic [7:0] corr;
	logic       sh_c;
	logic [7:0] res;
	logic [3:0] fo;
	logic       wr;

	assign a    = req.operand_a;
	assign b    = req.operand_b;
	assign f    = req.flags_in;
	assign sel  = req.code[5:3];
	assign grp  = req.code[7:6];
	assign mask = 8'b1 << sel;

	assign cia  = (sel == ALU_ADC) ? f[FLAG_C] : 1'b0;
	assign cis  = (sel == ALU_SBC) ? f[FLAG_C] : 1'b0;
	assign add9 = {1'b0, a} + {1'b0, b} + {8'b0, cia};
	assign addh = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cia};
	// top bit of each difference is the borrow into that position
	assign sub9 = {1'b0, a} - {1'b0, b} - {8'b0, cis};
	assign subh = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cis};

	always_comb begin
		res  = a;
		fo   = f;
		wr   = 1'b0;
		corr = 8'h00;
		sh_c = 1'b0;
		case (req.op)
			OP_ALU: begin
				wr = 1'b1;
				fo = 4'b0;
				case (sel) inside
					ALU_ADD, ALU_ADC: begin
						res = add9[7:0];
						fo[FLAG_H] = addh[4];
						fo[FLAG_C] = add9[8];
					end
					ALU_SUB, ALU_SBC, ALU_CP: begin
						res = sub9[7:0];
						fo[FLAG_N] = 1'b1;
						fo[FLAG_H] = subh[4];
						fo[FLAG_C] = sub9[8];
					end
					ALU_AND: begin
						res = a & b;
						fo[FLAG_H] = 1'b1;
					end
					ALU_XOR: res = a ^ b;
					default: res = a | b;
				endcase
				fo[FLAG_Z] = (res == 8'h00);
				// compare keeps the accumulator and skips write-back
				if (sel == ALU_CP) begin
					res = a;
					wr  = 1'b0;
				end
			end
			OP_ACC: begin
				wr = 1'b1;
				case (sel)
					ACC_RLCA: begin
						res = {a[6:0], a[7]};
						fo  = {3'b0, a[7]};
					end
					ACC_RRCA: begin
						res = {a[0], a[7:1]};
						fo  = {3'b0, a[0]};
					end
					ACC_RLA: begin
						res = {a[6:0], f[FLAG_C]};
						fo  = {3'b0, a[7]};
					end
					ACC_RRA: begin
						res = {f[FLAG_C], a[7:1]};
						fo  = {3'b0, a[0]};
					end
					ACC_DAA: begin
						fo = {1'b0, f[FLAG_N], 1'b0, f[FLAG_C]};
						if (f[FLAG_N]) begin
							if (f[FLAG_H]) corr = corr | DAA_LO;
							if (f[FLAG_C]) corr = corr | DAA_HI;
							res = a - corr;
						end else begin
							if (f[FLAG_H] || a[3:0] > DAA_NIB) corr = corr | DAA_LO;
							if (f[FLAG_C] || a > DAA_LIMIT) begin
								corr = corr | DAA_HI;
								fo[FLAG_C] = 1'b1;
							end
							res = a + corr;
						end
						fo[FLAG_Z] = (res == 8'h00);
					end
					ACC_CPL: begin
						res = ~a;
						fo  = f | 4'b0110;
					end
					ACC_SCF: fo = {f[FLAG_Z], 3'b001};
					default: fo = {f[FLAG_Z], 2'b00, ~f[FLAG_C]};
				endcase
			end
			OP_INC: begin
				wr  = 1'b1;
				res = a + 8'd1;
				fo  = {res == 8'h00, 1'b0, a[3:0] == 4'hF, f[FLAG_C]};
			end
			OP_DEC: begin
				wr  = 1'b1;
				res = a - 8'd1;
				fo  = {res == 8'h00, 1'b1, a[3:0] == 4'h0, f[FLAG_C]};
			end
			OP_PREF: begin
				wr = 1'b1;
				case (grp)
					GRP_SHIFT: begin
						case (sel)
							SH_RLC: begin
								sh_c = a[7];
								res  = {a[6:0], a[7]};
							end
							SH_RRC: begin
								sh_c = a[0];
								res  = {a[0], a[7:1]};
							end
							SH_RL: begin
								sh_c = a[7];
								res  = {a[6:0], f[FLAG_C]};
							end
							SH_RR: begin
								sh_c = a[0];
								res  = {f[FLAG_C], a[7:1]};
							end
							SH_SLA: begin
								sh_c = a[7];
								res  = {a[6:0], 1'b0};
							end
							SH_SRA: begin
								sh_c = a[0];
								res  = {a[7], a[7:1]};
							end
							SH_SWAP: res = {a[3:0], a[7:4]};
							default: begin
								sh_c = a[0];
								res  = {1'b0, a[7:1]};
							end
						endcase
						fo = {res == 8'h00, 2'b00, sh_c};
					end
					GRP_BIT: begin
						wr = 1'b0;
						fo = {(a & mask) == 8'h00, 1'b0, 1'b1, f[FLAG_C]};
					end
					GRP_RES: res = a & ~mask;
					default: res = a | mask;
				endcase
			end
			default: ;
		endcase
	end

	assign rsp.result       = res;
	assign rsp.flags_out    = fo;
	assign rsp.write_result = wr;

endmodule

// ===== tb/sv/alu_result_checker.sv =====
module alu_result_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  ebalu_pkg::alu_req_t request,
	input  logic                done,
	input  ebalu_pkg::alu_rsp_t response,
	output int                  mismatch_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ebalu_pkg::*;

	alu_rsp_t expected_q[$];
	alu_rsp_t want;

	function automatic alu_rsp_t predict_alu_result(alu_req_t rq);
		alu_rsp_t   rsp;
		logic [7:0] a;
		logic [7:0] b;
		logic [3:0] f;
		logic [2:0] sel;
		logic       ci;
		logic       c;
		logic [8:0] sum;
		logic [4:0] lo;
		logic [7:0] corr;
		logic [7:0] mask;
		a = rq.operand_a;
		b = rq.operand_b;
		f = rq.flags_in;
		sel = rq.code[5:3];
		mask = 8'h01 << sel;
		rsp.result = a;
		rsp.flags_out = f;
		rsp.write_result = 1'b0;
		case (rq.op)
			OP_ALU: begin
				rsp.flags_out = 4'h0;
				rsp.write_result = 1'b1;
				case (sel)
					ALU_ADD, ALU_ADC: begin
						ci = (sel == ALU_ADC) ? f[FLAG_C] : 1'b0;
						sum = {1'b0, a} + {1'b0, b} + {8'b0, ci};
						lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, ci};
						rsp.result = sum[7:0];
						rsp.flags_out[FLAG_H] = lo[4];
						rsp.flags_out[FLAG_C] = sum[8];
					end
					ALU_SUB, ALU_SBC, ALU_CP: begin
						ci = (sel == ALU_SBC) ? f[FLAG_C] : 1'b0;
						rsp.result = a - b - {7'b0, ci};
						rsp.flags_out[FLAG_N] = 1'b1;
						rsp.flags_out[FLAG_H] =
							{1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'b0, ci});
						rsp.flags_out[FLAG_C] = {1'b0, a} < ({1'b0, b} + {8'b0, ci});
					end
					ALU_AND: begin
						rsp.result = a & b;
						rsp.flags_out[FLAG_H] = 1'b1;
					end
					ALU_XOR: rsp.result = a ^ b;
					default: rsp.result = a | b;
				endcase
				rsp.flags_out[FLAG_Z] = (rsp.result == 8'h00);
				// compare keeps the accumulator and writes nothing
				if (sel == ALU_CP) begin
					rsp.result = a;
					rsp.write_result = 1'b0;
				end
			end
			OP_ACC: begin
				rsp.write_result = 1'b1;
				rsp.flags_out = 4'h0;
				case (sel)
					ACC_RLCA: begin
						rsp.result = {a[6:0], a[7]};
						rsp.flags_out[FLAG_C] = a[7];
					end
					ACC_RRCA: begin
						rsp.result = {a[0], a[7:1]};
						rsp.flags_out[FLAG_C] = a[0];
					end
					ACC_RLA: begin
						rsp.result = {a[6:0], f[FLAG_C]};
						rsp.flags_out[FLAG_C] = a[7];
					end
					ACC_RRA: begin
						rsp.result = {f[FLAG_C], a[7:1]};
						rsp.flags_out[FLAG_C] = a[0];
					end
					ACC_DAA: begin
						corr = 8'h00;
						rsp.flags_out[FLAG_N] = f[FLAG_N];
						rsp.flags_out[FLAG_C] = f[FLAG_C];
						if (f[FLAG_N]) begin
							if (f[FLAG_H])
								corr = corr | DAA_LO;
							if (f[FLAG_C])
								corr = corr | DAA_HI;
							rsp.result = a - corr;
						end else begin
							if (f[FLAG_H] || a[3:0] > DAA_NIB)
								corr = corr | DAA_LO;
							if (f[FLAG_C] || a > DAA_LIMIT) begin
								corr = corr | DAA_HI;
								rsp.flags_out[FLAG_C] = 1'b1;
							end
							rsp.result = a + corr;
						end
						rsp.flags_out[FLAG_Z] = (rsp.result == 8'h00);
					end
					ACC_CPL: begin
						rsp.result = ~a;
						rsp.flags_out = f;
						rsp.flags_out[FLAG_N] = 1'b1;
						rsp.flags_out[FLAG_H] = 1'b1;
					end
					ACC_SCF: begin
						rsp.flags_out[FLAG_Z] = f[FLAG_Z];
						rsp.flags_out[FLAG_C] = 1'b1;
					end
					default: begin
						rsp.flags_out[FLAG_Z] = f[FLAG_Z];
						rsp.flags_out[FLAG_C] = ~f[FLAG_C];
					end
				endcase
			end
			OP_INC: begin
				rsp.result = a + 8'h01;
				rsp.write_result = 1'b1;
				rsp.flags_out = 4'h0;
				rsp.flags_out[FLAG_Z] = (rsp.result == 8'h00);
				rsp.flags_out[FLAG_H] = (a[3:0] == 4'hF);
				rsp.flags_out[FLAG_C] = f[FLAG_C];
			end
			OP_DEC: begin
				rsp.result = a - 8'h01;
				rsp.write_result = 1'b1;
				rsp.flags_out = 4'h0;
				rsp.flags_out[FLAG_Z] = (rsp.result == 8'h00);
				rsp.flags_out[FLAG_N] = 1'b1;
				rsp.flags_out[FLAG_H] = (a[3:0] == 4'h0);
				rsp.flags_out[FLAG_C] = f[FLAG_C];
			end
			OP_PREF: begin
				rsp.write_result = 1'b1;
				case (rq.code[7:6])
					GRP_SHIFT: begin
						c = 1'b0;
						case (sel)
							SH_RLC: begin
								c = a[7];
								rsp.result = {a[6:0], a[7]};
							end
							SH_RRC: begin
								c = a[0];
								rsp.result = {a[0], a[7:1]};
							end
							SH_RL: begin
								c = a[7];
								rsp.result = {a[6:0], f[FLAG_C]};
							end
							SH_RR: begin
								c = a[0];
								rsp.result = {f[FLAG_C], a[7:1]};
							end
							SH_SLA: begin
								c = a[7];
								rsp.result = {a[6:0], 1'b0};
							end
							SH_SRA: begin
								c = a[0];
								rsp.result = {a[7], a[7:1]};
							end
							SH_SWAP: rsp.result = {a[3:0], a[7:4]};
							default: begin
								c = a[0];
								rsp.result = {1'b0, a[7:1]};
							end
						endcase
						rsp.flags_out = 4'h0;
						rsp.flags_out[FLAG_Z] = (rsp.result == 8'h00);
						rsp.flags_out[FLAG_C] = c;
					end
					GRP_BIT: begin
						rsp.write_result = 1'b0;
						rsp.flags_out = 4'h0;
						rsp.flags_out[FLAG_Z] = ((a & mask) == 8'h00);
						rsp.flags_out[FLAG_H] = 1'b1;
						rsp.flags_out[FLAG_C] = f[FLAG_C];
					end
					GRP_RES: rsp.result = a & ~mask;
					default: rsp.result = a | mask;
				endcase
			end
			default: ;
		endcase
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			mismatch_count <= 0;
			pending <= 0;
		end else begin
			// retire the oldest item before queueing the one accepted at this edge
			if (done) begin
				if (expected_q.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result %02h flags %h write %b with nothing expected",
							$realtime, response.result, response.flags_out,
							response.write_result);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (want.result != response.result
						|| want.flags_out != response.flags_out
						|| want.write_result != response.write_result) begin
						if (mismatch_count < 10)
							$display("%0t: result exp %02h got %02h, flags exp %h got %h, write exp %b got %b",
								$realtime, want.result, response.result, want.flags_out,
								response.flags_out, want.write_result,
								response.write_result);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_alu_result(request));
			pending <= expected_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ebalu_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 384;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	alu_req_t request = '0;
	logic     done;
	alu_rsp_t response;
	int       mismatch_count;
	int       pending;
	int       idle_pct = 0;
	int       stall_cycles = 0;

	eight_bit_alu_with_bit_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response)
	);

	alu_result_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.done           (done),
		.response       (response),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// count cycles in which neither side moves an item
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_op(input logic [2:0] op, input logic [7:0] code,
		input logic [7:0] a, input logic [7:0] b, input logic [3:0] f);
		logic taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		request.op <= op;
		request.code <= code;
		request.operand_a <= a;
		request.operand_b <= b;
		request.flags_in <= f;
		start <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
	endtask

	// hold start low until every queued item has come back
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte;
		logic [7:0] corners[10];
		corners = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A, 8'hF0, 8'hFF};
		if ($urandom_range(0, 99) < 70)
			return 8'($urandom);
		return corners[$urandom_range(0, 9)];
	endfunction

	initial begin
		logic [2:0] op;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners, covering every operation family and special cases
		send_op(OP_ALU, {2'b00, ALU_ADD, 3'b000}, 8'hFF, 8'h01, 4'h0);
		send_op(OP_ALU, {2'b00, ALU_ADC, 3'b000}, 8'h0F, 8'h00, 4'h1);
		send_op(OP_ALU, {2'b00, ALU_SUB, 3'b000}, 8'h00, 8'h01, 4'h0);
		send_op(OP_ALU, {2'b00, ALU_SBC, 3'b000}, 8'h10, 8'h0F, 4'h1);
		send_op(OP_ALU, {2'b00, ALU_AND, 3'b000}, 8'hF0, 8'h0F, 4'hF);
		send_op(OP_ALU, {2'b00, ALU_XOR, 3'b000}, 8'hA5, 8'hA5, 4'h0);
		send_op(OP_ALU, {2'b00, ALU_OR, 3'b000}, 8'h00, 8'h00, 4'h0);
		send_op(OP_ALU, {2'b11, ALU_CP, 3'b111}, 8'h42, 8'h42, 4'h0);
		send_op(OP_ACC, {2'b00, ACC_RLCA, 3'b111}, 8'h80, 8'h00, 4'hE);
		send_op(OP_ACC, {2'b00, ACC_RRCA, 3'b111}, 8'h01, 8'h00, 4'h0);
		send_op(OP_ACC, {2'b00, ACC_RLA, 3'b111}, 8'h80, 8'hFF, 4'h1);
		send_op(OP_ACC, {2'b00, ACC_RRA, 3'b111}, 8'h01, 8'h00, 4'h1);
		send_op(OP_ACC, {2'b00, ACC_DAA, 3'b111}, 8'h9A, 8'h00, 4'h0);
		send_op(OP_ACC, {2'b00, ACC_DAA, 3'b111}, 8'h00, 8'h00, 4'h7);
		send_op(OP_ACC, {2'b00, ACC_CPL, 3'b111}, 8'h5A, 8'h00, 4'h0);
		send_op(OP_ACC, {2'b00, ACC_SCF, 3'b111}, 8'h33, 8'h00, 4'hE);
		send_op(OP_ACC, {2'b00, ACC_CCF, 3'b111}, 8'h33, 8'h00, 4'h1);
		send_op(OP_INC, 8'hFF, 8'hFF, 8'h00, 4'h1);
		send_op(OP_DEC, 8'h00, 8'h00, 8'hFF, 4'h0);
		send_op(OP_DEC, 8'h5A, 8'h10, 8'h00, 4'hF);
		send_op(OP_PREF, {GRP_SHIFT, SH_SWAP, 3'b000}, 8'hF0, 8'h00, 4'h0);
		send_op(OP_PREF, {GRP_SHIFT, SH_SRA, 3'b000}, 8'h81, 8'h00, 4'h0);
		send_op(OP_PREF, {GRP_BIT, 3'd7, 3'b000}, 8'h7F, 8'h00, 4'h1);
		send_op(OP_PREF, {GRP_RES, 3'd0, 3'b000}, 8'hFF, 8'h00, 4'h5);
		send_op(OP_PREF, {GRP_SET, 3'd7, 3'b000}, 8'h00, 8'h00, 4'hA);
		send_op(3'd7, 8'hFF, 8'hFF, 8'hFF, 4'hF);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 26 : (phase == 1) ? 62 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 4)
					op = 3'($urandom_range(5, 7));
				else
					op = 3'($urandom_range(0, 4));
				send_op(op, 8'($urandom), pick_byte(), pick_byte(), 4'($urandom));
				if (n == PHASE_ITEMS / 2)
					drain();
			end
			drain();
		end

		repeat (6) @(negedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
